// ===== src/dccp_pkg.sv =====
package dccp_pkg;

  // drive geometry and limits
  localparam int unsigned NUM_DRIVES     = 4;
  localparam int unsigned SPT            = 17;
  localparam int unsigned HEADS          = 8;
  localparam int unsigned SECLEN         = 2048;
  localparam int unsigned MAX_FORMAT_RUN = 64;

  // field widths
  localparam int unsigned TRK_W  = 16;
  localparam int unsigned LEN_W  = 12;
  localparam int unsigned OFF_W  = 35;
  localparam int unsigned ADDR_W = 24;
  localparam int unsigned DRV_W  = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_FORMAT_RUN + 1);
  // track * HEADS + head, head up to 255
  localparam int unsigned TH_W   = $clog2(65535 * HEADS + 256);
  // (track * HEADS + head) * SPT + sector
  localparam int unsigned LIN_W  = TH_W + $clog2(SPT + 1) + 1;

  // command codes
  localparam logic [7:0] CMD_READ    = 8'd0;
  localparam logic [7:0] CMD_WRITE   = 8'd1;
  localparam logic [7:0] CMD_RDHDR   = 8'd2;
  localparam logic [7:0] CMD_FORMAT  = 8'd3;
  localparam logic [7:0] CMD_SPECIFY = 8'd4;
  localparam logic [7:0] CMD_SENSE   = 8'd5;
  localparam logic [7:0] CMD_NOP     = 8'd6;

  // status codes
  localparam logic [7:0] ST_GOOD     = 8'hFF;
  localparam logic [7:0] ST_ILLEGAL  = 8'hA0;
  localparam logic [7:0] ST_SENSE    = 8'hE2;

  // transfer kinds
  localparam logic [1:0] XFER_NONE   = 2'd0;
  localparam logic [1:0] XFER_READ   = 2'd1;
  localparam logic [1:0] XFER_WRITE  = 2'd2;
  localparam logic [1:0] XFER_FILL   = 2'd3;

  typedef struct packed {
    logic [1:0]        drive_select;
    logic              toward_zero;
    logic [15:0]       step_count;
    logic [2:0]        head_select_raw;
    logic [ADDR_W-1:0] dma_address;
    logic [7:0]        arg_a;
    logic [7:0]        arg_b;
    logic [7:0]        arg_c;
    logic [7:0]        arg_d;
    logic [7:0]        cmd;
    logic [ADDR_W-1:0] link_address;
  } req_word_t;

  typedef struct packed {
    logic [7:0]        status;
    logic [1:0]        transfer_kind;
    logic [OFF_W-1:0]  disk_offset;
    logic [LEN_W-1:0]  transfer_length;
    logic [ADDR_W-1:0] memory_address;
    logic [7:0]        fill_value;
    logic [ADDR_W-1:0] next_command;
    logic              track_mismatch;
    logic              last;
  } res_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MULH,
    ST_MULS,
    ST_MULL,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic mulh;
    logic muls;
    logic mull;
    logic emit;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic final_word;
  } stat_t;

  // drive number folded onto the drives that exist
  function automatic logic [DRV_W-1:0] drive_index(input logic [1:0] sel);
    logic [2:0] v;
    v = {1'b0, sel};
    for (int k = 0; k < 4; k++) begin
      if (v >= 3'(NUM_DRIVES)) begin
        v = v - 3'(NUM_DRIVES);
      end
    end
    return DRV_W'(v);
  endfunction

  // 128 * (code + 1), clamped to the sector buffer
  function automatic logic [LEN_W-1:0] size_from_code(input logic [7:0] code);
    logic [15:0] n;
    n = {({1'b0, code} + 9'd1), 7'd0};
    return (n > 16'(SECLEN)) ? LEN_W'(SECLEN) : LEN_W'(n);
  endfunction

endpackage

// ===== src/dccp_ctrl.sv =====
module dccp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  dccp_pkg::stat_t stat_i,
  output dccp_pkg::ctrl_t ctrl_o,
  output logic           busy
);
  import dccp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_STEP;
      end
      ST_STEP: state_d = ST_MULH;
      ST_MULH: state_d = ST_MULS;
      ST_MULS: state_d = ST_MULL;
      ST_MULL: state_d = ST_EMIT;
      ST_EMIT: begin
        if (stat_i.final_word) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy        = 1'b0;
        ctrl_o.load = start;
      end
      ST_STEP: ctrl_o.step = 1'b1;
      ST_MULH: ctrl_o.mulh = 1'b1;
      ST_MULS: ctrl_o.muls = 1'b1;
      ST_MULL: ctrl_o.mull = 1'b1;
      ST_EMIT: ctrl_o.emit = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// ===== src/dccp_dp.sv =====
module dccp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dccp_pkg::req_word_t req_i,
  input  dccp_pkg::ctrl_t     ctrl_i,
  output dccp_pkg::stat_t     stat_o,
  output dccp_pkg::res_word_t res_o
);
  import dccp_pkg::*;

  req_word_t        req_q;
  logic [DRV_W-1:0] drv_q;
  logic [TRK_W-1:0] tracks_q [NUM_DRIVES];
  logic [LEN_W-1:0] secb_q   [NUM_DRIVES];
  logic [TRK_W-1:0] trk_q, trk_d;
  logic [LEN_W-1:0] len_q;
  logic [CNT_W-1:0] cnt_q;
  logic [TH_W-1:0]  th_q;
  logic [LIN_W-1:0] lin_q;
  logic [OFF_W-1:0] off_q;

  logic             is_fmt;
  logic [TRK_W:0]   up_sum;
  logic [TRK_W-1:0] cur_trk;
  logic [7:0]       fmt_n;
  logic [7:0]       head_sel;
  logic [7:0]       sec_sel;

  assign is_fmt   = (req_q.cmd == CMD_FORMAT);
  assign cur_trk  = tracks_q[drv_q];
  assign up_sum   = {1'b0, cur_trk} + {1'b0, req_q.step_count};
  assign fmt_n    = req_q.arg_b ^ 8'hFF;
  assign head_sel = is_fmt ? {5'd0, req_q.head_select_raw ^ 3'h7} : req_q.arg_c;
  assign sec_sel  = is_fmt ? 8'd0 : req_q.arg_d;

  // seek: floor at zero going in, saturate going out
  always_comb begin
    if (req_q.toward_zero) begin
      trk_d = (cur_trk >= req_q.step_count) ? cur_trk - req_q.step_count : '0;
    end else begin
      trk_d = up_sum[TRK_W] ? '1 : up_sum[TRK_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q <= req_i;
      drv_q <= drive_index(req_i.drive_select);
    end
    if (ctrl_i.step) begin
      trk_q <= trk_d;
      if (is_fmt) begin
        len_q <= size_from_code(req_q.arg_c ^ 8'hFF);
        cnt_q <= (fmt_n > 8'(MAX_FORMAT_RUN)) ? CNT_W'(MAX_FORMAT_RUN) : CNT_W'(fmt_n);
      end else begin
        len_q <= (secb_q[drv_q] > LEN_W'(SECLEN)) ? LEN_W'(SECLEN) : secb_q[drv_q];
        cnt_q <= CNT_W'(1);
      end
    end
    if (ctrl_i.mulh) begin
      th_q <= TH_W'(trk_q) * TH_W'(HEADS) + TH_W'(head_sel);
    end
    if (ctrl_i.muls) begin
      lin_q <= LIN_W'(th_q) * LIN_W'(SPT) + LIN_W'(sec_sel);
    end
    if (ctrl_i.mull) begin
      off_q <= OFF_W'(lin_q) * OFF_W'(SECLEN);
    end
    if (ctrl_i.emit) begin
      // next sector of a format run
      off_q <= off_q + OFF_W'(SECLEN);
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DRIVES; i++) begin
        tracks_q[i] <= '0;
        secb_q[i]   <= '0;
      end
    end else if (ctrl_i.step) begin
      tracks_q[drv_q] <= trk_d;
      if (req_q.cmd == CMD_SPECIFY) begin
        secb_q[drv_q] <= size_from_code(req_q.arg_d);
      end
    end
  end

  assign stat_o.final_word = !(is_fmt && (cnt_q > CNT_W'(1)));

  always_comb begin
    res_o                = '0;
    res_o.next_command   = req_q.link_address;
    res_o.last           = stat_o.final_word;
    res_o.status         = ST_GOOD;
    case (req_q.cmd) inside
      CMD_READ, CMD_WRITE: begin
        res_o.transfer_kind   = (req_q.cmd == CMD_READ) ? XFER_READ : XFER_WRITE;
        res_o.disk_offset     = off_q;
        res_o.transfer_length = len_q;
        res_o.memory_address  = req_q.dma_address;
        res_o.track_mismatch  = ({req_q.arg_b, req_q.arg_a} != trk_q);
      end
      CMD_FORMAT: begin
        if (cnt_q != '0) begin
          res_o.transfer_kind   = XFER_FILL;
          res_o.disk_offset     = off_q;
          res_o.transfer_length = len_q;
          res_o.fill_value      = req_q.arg_d;
        end
      end
      CMD_SENSE: begin
        res_o.status = ST_SENSE | {7'd0, (trk_q != '0)};
      end
      CMD_RDHDR, CMD_SPECIFY, CMD_NOP: begin
        res_o.status = ST_GOOD;
      end
      default: begin
        res_o.status = ST_ILLEGAL;
      end
    endcase
  end

endmodule

// ===== src/disk_channel_command_processor_top.sv =====
// disk channel command processor: a command word is taken when start is high
// and busy is low; the drive's track is stepped first, then the block emits
// its result words on res_word_o, each shown for exactly one cycle with
// res_valid_o high, and the receiver cannot hold them off. a command passes
// through the seek and then the three constant multiplies of the offset
// computation before its first result word; format then puts out one word per
// cycle, one per sector, up to 64, and every other command, a format with no
// sectors included, puts out a single word. busy stays high from the seek
// through the last word.
// the next command can be taken in the cycle after the last word.
module disk_channel_command_processor_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  dccp_pkg::req_word_t cmd_word_i,
  output logic                busy,
  output logic                res_valid_o,
  output dccp_pkg::res_word_t res_word_o
);
  import dccp_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // sequencer: seek, offset multiplies, result loop
  dccp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  // per-drive track and sector size, offset arithmetic, result assembly
  dccp_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cmd_word_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .res_o  (res_word_o)
  );

  // one result word per cycle of the emit state
  assign res_valid_o = ctrl.emit;

endmodule
